>>> design/wsts_pkg.sv
// ----------------------------------------------------------------------------
// wsts_pkg: shared types and constants for the work stealing task scheduler
// Command and status codes, sizing constants, datapath widths.
// ----------------------------------------------------------------------------
package wsts_pkg;
    localparam int NUM_CORES   = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int CW = $clog2(NUM_CORES);       // core index width
    localparam int QW = $clog2(QUEUE_DEPTH);     // slot index width
    localparam int LW = $clog2(QUEUE_DEPTH + 1); // length width
    localparam int NW = $clog2(NUM_CORES + 1);   // active count width
    localparam int AW = CW + QW;
    localparam int TW = 31;

    localparam logic [2:0] CMD_SPAWN = 3'd0;
    localparam logic [2:0] CMD_RUN   = 3'd1;
    localparam logic [2:0] CMD_SLEEP = 3'd2;
    localparam logic [2:0] CMD_SHUT  = 3'd3;
    localparam logic [2:0] CMD_SIZE  = 3'd4;

    localparam logic [2:0] ST_ASSIGNED = 3'd0;
    localparam logic [2:0] ST_FAIL     = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_MOVED    = 3'd4;
    localparam logic [2:0] ST_DELETED  = 3'd5;
    localparam logic [2:0] ST_SIZE     = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    // scan request to the shared compare unit
    typedef struct packed {
        logic          start;
        logic          find_max;
        logic          use_skip;
        logic [CW-1:0] skip;
    } t_scan_req;

    typedef struct packed {
        logic          done;
        logic          found;
        logic [CW-1:0] best;
    } t_scan_rsp;
endpackage

>>> design/work_stealing_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler_unit: per-core task deques with load balancing
//
// Commands enter on the s_axis group: tdata holds cmd, core_id, task_id.
// Results leave on m_axis: tdata holds status, core_index, task_value,
// task_count; tlast marks the final result of a command.
// core_count is written through the APB port at address 0.
// One command at a time: s_axis_tready is low until the sequencer is back
// in idle and its last result has been taken. Each least/most loaded search
// runs on one shared compare unit stepping one core per cycle. A run that
// finds or leaves its core empty may be followed by a steal before the next
// item is accepted. Sleep gives a result for each task it moves, shutdown
// one for each task it deletes. A result waits in the output register while
// the receiver stalls; the sequencer holds. Reset empties all queues and
// sets core_count to 0; task storage itself is not cleared.
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler_unit import wsts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cmd[2:0] core_id[6:3] task_id[37:7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[2:0] core_index[5:3] task_value[36:6] task_count[40:37]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DEC   = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_SPAWN = 11'b00000001000,
        S_RUNRD = 11'b00000010000,
        S_STEAL = 11'b00000100000,
        S_STRD  = 11'b00001000000,
        S_SLRD  = 11'b00010000000,
        S_SHRD  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WR    = 11'b10000000000
    } t_state;

    t_state r_st, n_st;
    logic [3:0] r_cfg, n_cfg;
    logic [NUM_CORES-1:0][QW-1:0] r_head, n_head;
    logic [NUM_CORES-1:0][LW-1:0] r_len, n_len;
    logic [TW-1:0] r_mem [NUM_CORES*QUEUE_DEPTH];
    logic [TW-1:0] r_rd;
    logic [2:0]  r_cmd, n_cmd;
    logic [3:0]  r_cid, n_cid;
    logic [TW-1:0] r_tid, n_tid;
    logic [NW-1:0] r_sc, n_sc;      // shutdown core
    logic [CW-1:0] r_tgt, n_tgt;
    logic [2:0]  r_ost, n_ost;
    logic [CW-1:0] r_oci, n_oci;
    logic [TW-1:0] r_oval, n_oval;
    logic [LW-1:0] r_ocnt, n_ocnt;
    logic        r_olast, n_olast;
    logic        r_ov, n_ov;
    logic        r_any, n_any;
    logic        r_scan_ph, n_scan_ph;   // read phase: 0 address, 1 data valid
    logic [AW-1:0] r_ra, n_ra;
    logic        r_req_start, n_req_start;
    logic        r_req_max, n_req_max;
    logic        r_req_use, n_req_use;
    logic        w_wr_en;
    logic [AW-1:0] w_wa;
    logic [TW-1:0] w_wd;
    t_scan_req w_req;
    t_scan_rsp w_rsp;
    logic [NW-1:0] w_act;
    logic [CW-1:0] w_c;
    logic [CW-1:0] w_sc;
    logic [CW-1:0] w_best;
    logic w_valid;
    logic w_later;
    logic w_last_del;

    assign w_act = (r_cfg > 4'(NUM_CORES)) ? NW'(NUM_CORES) : NW'(r_cfg);
    assign w_c = r_cid[CW-1:0];
    assign w_sc = r_sc[CW-1:0];
    assign w_best = w_rsp.best;
    assign w_valid = ({1'b0, r_cid} < 5'(w_act));
    assign w_req = '{start: r_req_start, find_max: r_req_max, use_skip: r_req_use, skip: w_c};

    wsts_scan u_scan (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                      .i_active(w_act), .i_len(r_len), .o_rsp(w_rsp));

    function automatic logic [AW-1:0] f_slot(logic [CW-1:0] c, logic [QW-1:0] h,
                                             logic [LW-1:0] k);
        logic [QW-1:0] s;
        s = h + k[QW-1:0];
        return {c, s};
    endfunction

    assign pready = 1'b1;
    assign prdata = {28'd0, r_cfg};
    assign s_axis_tready = (r_st == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'd0, r_ocnt, r_oval, r_oci, r_ost};

    // last deleted task: this core's last and no later active core has tasks
    always_comb begin
        w_later = 1'b0;
        for (int i = 0; i < NUM_CORES; i++)
            if (NW'(i) > r_sc && NW'(i) < w_act && r_len[i] != '0) w_later = 1'b1;
    end
    assign w_last_del = (r_len[w_sc] == LW'(1)) && !w_later;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[r_ra];
    end

    always_comb begin
        n_st = r_st; n_cfg = r_cfg; n_head = r_head; n_len = r_len;
        n_cmd = r_cmd; n_cid = r_cid; n_tid = r_tid; n_sc = r_sc; n_tgt = r_tgt;
        n_ost = r_ost; n_oci = r_oci; n_oval = r_oval; n_ocnt = r_ocnt;
        n_olast = r_olast;
        n_ov = r_ov && !m_axis_tready;
        n_any = r_any; n_scan_ph = r_scan_ph; n_ra = r_ra;
        n_req_start = 1'b0; n_req_max = r_req_max; n_req_use = r_req_use;
        w_wr_en = 1'b0; w_wa = '0; w_wd = '0;
        if (psel && penable && pwrite && paddr == 2'd0) n_cfg = pwdata[3:0];
        case (r_st)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_cmd = s_axis_tdata[2:0]; n_cid = s_axis_tdata[6:3];
                    n_tid = s_axis_tdata[37:7]; n_sc = '0; n_any = 1'b0;
                    n_scan_ph = 1'b0; n_st = S_DEC;
                end
            end
            S_DEC: begin
                n_ost = ST_FAIL; n_oci = '0; n_oval = '0; n_ocnt = '0; n_olast = 1'b1;
                case (r_cmd)
                    CMD_SPAWN: begin
                        if (r_tid == '0 || w_act == '0) n_st = S_EMIT;
                        else begin
                            n_req_max = 1'b0; n_req_use = 1'b0; n_req_start = 1'b1;
                            n_st = S_SCAN;
                        end
                    end
                    CMD_RUN: begin
                        if (!w_valid) n_st = S_EMIT;
                        else if (r_len[w_c] == '0) begin
                            n_ost = ST_NONE; n_oci = w_c; n_st = S_STEAL;
                        end else begin
                            n_ra = f_slot(w_c, r_head[w_c], '0); n_st = S_RUNRD;
                        end
                    end
                    CMD_SLEEP: begin
                        if (!w_valid || w_act < NW'(2)) n_st = S_EMIT;
                        else if (r_len[w_c] == '0) begin
                            n_ost = ST_NONE; n_oci = w_c; n_st = S_EMIT;
                        end else begin
                            n_req_max = 1'b0; n_req_use = 1'b1; n_req_start = 1'b1;
                            n_st = S_SCAN;
                        end
                    end
                    CMD_SHUT: begin
                        n_st = S_SHRD;
                    end
                    CMD_SIZE: begin
                        if (w_valid) begin
                            n_ost = ST_SIZE; n_oci = w_c; n_ocnt = r_len[w_c];
                        end
                        n_st = S_EMIT;
                    end
                    default: n_st = S_EMIT;
                endcase
            end
            S_SCAN: begin
                if (w_rsp.done) begin
                    n_tgt = w_best;
                    n_scan_ph = 1'b0;
                    case (r_cmd)
                        CMD_SPAWN: begin
                            n_oci = w_best; n_oval = r_tid; n_olast = 1'b1;
                            n_st = S_EMIT;
                            if (r_len[w_best] >= LW'(QUEUE_DEPTH)) n_ost = ST_FULL;
                            else begin
                                n_ost = ST_ASSIGNED;
                                w_wr_en = 1'b1; w_wd = r_tid;
                                w_wa = f_slot(w_best, r_head[w_best], r_len[w_best]);
                                n_len[w_best] = r_len[w_best] + 1'b1;
                            end
                        end
                        CMD_RUN: begin
                            if (w_rsp.found && r_len[w_best] != '0) begin
                                n_ra = f_slot(w_best, r_head[w_best],
                                              r_len[w_best] - 1'b1);
                                n_len[w_best] = r_len[w_best] - 1'b1;
                                n_st = S_STRD;
                            end else n_st = S_IDLE;
                        end
                        default: begin
                            n_ra = f_slot(w_c, r_head[w_c], r_len[w_c] - 1'b1);
                            n_st = S_SLRD;
                        end
                    endcase
                end
            end
            S_RUNRD: begin
                n_st = S_WR;
            end
            S_WR: begin
                if (r_cmd == CMD_RUN) begin
                    n_ost = ST_RUNNING; n_oci = w_c; n_oval = r_rd;
                    n_head[w_c] = r_head[w_c] + 1'b1;
                    n_len[w_c] = r_len[w_c] - 1'b1;
                    n_olast = 1'b1;
                    n_st = S_STEAL;
                end else n_st = S_SHRD;
            end
            S_STEAL: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1;
                    if (r_len[w_c] == '0 && w_act >= NW'(2)) begin
                        n_req_max = 1'b1; n_req_use = 1'b1; n_req_start = 1'b1;
                        n_st = S_SCAN;
                    end else n_st = S_IDLE;
                end
            end
            S_STRD: begin
                if (r_scan_ph) begin
                    w_wr_en = 1'b1; w_wd = r_rd;
                    w_wa = f_slot(w_c, r_head[w_c], r_len[w_c]);
                    n_len[w_c] = r_len[w_c] + 1'b1;
                    n_scan_ph = 1'b0; n_st = S_IDLE;
                end else n_scan_ph = 1'b1;
            end
            S_SLRD: begin
                if (!r_scan_ph) n_scan_ph = 1'b1;
                else if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1; n_oci = r_tgt; n_oval = r_rd; n_scan_ph = 1'b0;
                    if (r_len[r_tgt] >= LW'(QUEUE_DEPTH)) begin
                        n_ost = ST_FULL; n_olast = 1'b1; n_st = S_IDLE;
                    end else begin
                        n_ost = ST_MOVED;
                        n_olast = (r_len[w_c] == LW'(1));
                        n_len[w_c] = r_len[w_c] - 1'b1;
                        w_wr_en = 1'b1; w_wd = r_rd;
                        w_wa = f_slot(r_tgt, r_head[r_tgt], r_len[r_tgt]);
                        n_len[r_tgt] = r_len[r_tgt] + 1'b1;
                        if (r_len[w_c] == LW'(1)) n_st = S_IDLE;
                        else begin
                            n_req_max = 1'b0; n_req_use = 1'b1; n_req_start = 1'b1;
                            n_st = S_SCAN;
                        end
                    end
                end
            end
            S_SHRD: begin
                if (r_sc >= w_act) begin
                    if (!r_any) begin
                        n_ost = ST_NONE; n_oci = '0; n_oval = '0; n_ocnt = '0;
                        n_olast = 1'b1; n_st = S_EMIT;
                    end else n_st = S_IDLE;
                end else if (!r_scan_ph) begin
                    if (r_len[w_sc] == '0) n_sc = r_sc + 1'b1;
                    else begin
                        n_ra = f_slot(w_sc, r_head[w_sc], '0);
                        n_scan_ph = 1'b1; n_st = S_WR;
                    end
                end else if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1; n_ost = ST_DELETED; n_oci = w_sc; n_oval = r_rd;
                    n_ocnt = '0; n_any = 1'b1; n_scan_ph = 1'b0;
                    n_head[w_sc] = r_head[w_sc] + 1'b1;
                    n_len[w_sc] = r_len[w_sc] - 1'b1;
                    n_olast = w_last_del;
                end
            end
            S_EMIT: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cfg <= '0; r_head <= '0; r_len <= '0; r_ov <= 1'b0;
            r_scan_ph <= 1'b0; r_req_start <= 1'b0;
        end else begin
            r_st <= n_st; r_cfg <= n_cfg; r_head <= n_head; r_len <= n_len; r_ov <= n_ov;
            r_scan_ph <= n_scan_ph; r_req_start <= n_req_start;
        end
        r_cmd <= n_cmd; r_cid <= n_cid; r_tid <= n_tid; r_sc <= n_sc; r_tgt <= n_tgt;
        r_ost <= n_ost; r_oci <= n_oci; r_oval <= n_oval; r_ocnt <= n_ocnt;
        r_olast <= n_olast; r_any <= n_any; r_ra <= n_ra;
        r_req_max <= n_req_max; r_req_use <= n_req_use;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tlast))
        else $error("last flag changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("ready while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted while busy");
endmodule

>>> design/wsts_scan.sv
// ----------------------------------------------------------------------------
// wsts_scan: shared min/max compare unit
// Walks the core lengths one per cycle and keeps the least or most loaded.
// ----------------------------------------------------------------------------
module wsts_scan import wsts_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_scan_req               i_req,
    input  logic [NW-1:0]           i_active,
    input  logic [NUM_CORES-1:0][LW-1:0] i_len,
    output t_scan_rsp               o_rsp
);
    logic          r_busy, n_busy;
    logic [NW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [CW-1:0] r_best, n_best;
    logic          r_done, n_done;
    logic          r_max, r_use;
    logic [CW-1:0] r_skip;
    logic [LW-1:0] w_cur, w_bl;
    logic          w_better;

    always_comb begin
        w_cur = i_len[r_idx[CW-1:0]];
        w_bl  = i_len[r_best];
        w_better = r_max ? (w_cur > w_bl) : (w_cur < w_bl);
        n_busy = r_busy; n_idx = r_idx; n_found = r_found; n_best = r_best;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1; n_idx = '0; n_found = 1'b0; n_best = '0;
        end else if (r_busy) begin
            if (r_idx >= i_active) begin
                n_busy = 1'b0; n_done = 1'b1;
            end else begin
                if (!(r_use && r_idx[CW-1:0] == r_skip) && (!r_found || w_better)) begin
                    n_found = 1'b1; n_best = r_idx[CW-1:0];
                end
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_idx <= n_idx; r_found <= n_found; r_best <= n_best;
        if (i_req.start) begin
            r_max <= i_req.find_max; r_use <= i_req.use_skip; r_skip <= i_req.skip;
        end
    end

    assign o_rsp = '{done: r_done, found: r_found, best: r_best};
endmodule

>>> tb/work_stealing_task_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler_unit_test: self-checking bench for the scheduler
// Drives commands on the slave stream and core_count over APB. A scoreboard
// model of the per-core deques predicts every result item, which is compared
// field by field with the master stream. Directed table first, then random
// traffic over several core counts, with bursty input and stalling output.
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler_unit_test;
    import wsts_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  core_index;
        logic [30:0] task_value;
        logic [3:0]  task_count;
        logic        last;
    } t_result;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  core_id;
        logic [30:0] task_id;
        logic        chk;
        logic [2:0]  st;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    work_stealing_task_scheduler_unit i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // scheduler model
    logic [30:0] mdl_store [NUM_CORES][QUEUE_DEPTH];
    int          mdl_head [NUM_CORES];
    int          mdl_len [NUM_CORES];
    int          mdl_cores;
    t_result     pending_results[$];
    logic [2:0]  last_st;
    int          errors = 0;
    int          cycles = 0;
    int          hold_off = 0;
    t_row        rows[$];

    function automatic int pick_core(bit want_max, int skip);
        int b;
        b = NUM_CORES;
        for (int i = 0; i < mdl_cores; i++) begin
            if (i == skip) continue;
            if (b == NUM_CORES || (want_max ? mdl_len[i] > mdl_len[b]
                                            : mdl_len[i] < mdl_len[b])) b = i;
        end
        return b;
    endfunction

    function automatic void push_result(logic [2:0] st, int c, logic [30:0] v, int n);
        t_result r;
        r.status = st; r.core_index = c[2:0]; r.task_value = v;
        r.task_count = n[3:0]; r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void add_back(int c, logic [30:0] v);
        mdl_store[c][(mdl_head[c] + mdl_len[c]) % QUEUE_DEPTH] = v;
        mdl_len[c]++;
    endfunction

    function automatic logic [30:0] take_front(int c);
        logic [30:0] v;
        v = mdl_store[c][mdl_head[c]];
        mdl_head[c] = (mdl_head[c] + 1) % QUEUE_DEPTH;
        mdl_len[c]--;
        return v;
    endfunction

    function automatic logic [30:0] take_back(int c);
        mdl_len[c]--;
        return mdl_store[c][(mdl_head[c] + mdl_len[c]) % QUEUE_DEPTH];
    endfunction

    function automatic void predict_command(logic [2:0] cmd, logic [3:0] cid,
                                            logic [30:0] tid);
        int t, v, n0;
        bit ok;
        n0 = pending_results.size();
        ok = cid < mdl_cores;
        case (cmd)
            CMD_SPAWN: begin
                t = pick_core(0, NUM_CORES);
                if (tid == 0 || t == NUM_CORES) push_result(ST_FAIL, 0, 0, 0);
                else if (mdl_len[t] >= QUEUE_DEPTH) push_result(ST_FULL, t, tid, 0);
                else begin
                    add_back(t, tid);
                    push_result(ST_ASSIGNED, t, tid, 0);
                end
            end
            CMD_RUN: begin
                if (!ok) push_result(ST_FAIL, 0, 0, 0);
                else begin
                    if (mdl_len[cid] > 0) push_result(ST_RUNNING, cid, take_front(cid), 0);
                    else push_result(ST_NONE, cid, 0, 0);
                    if (mdl_len[cid] == 0 && mdl_cores >= 2) begin
                        v = pick_core(1, cid);
                        if (v != NUM_CORES && mdl_len[v] > 0) add_back(cid, take_back(v));
                    end
                end
            end
            CMD_SLEEP: begin
                if (!ok || mdl_cores < 2) push_result(ST_FAIL, 0, 0, 0);
                else if (mdl_len[cid] == 0) push_result(ST_NONE, cid, 0, 0);
                else begin
                    while (mdl_len[cid] > 0) begin
                        t = pick_core(0, cid);
                        if (mdl_len[t] >= QUEUE_DEPTH) begin
                            push_result(ST_FULL, t, mdl_store[cid][(mdl_head[cid]
                                        + mdl_len[cid] - 1) % QUEUE_DEPTH], 0);
                            break;
                        end
                        v = take_back(cid);
                        add_back(t, v[30:0]);
                        push_result(ST_MOVED, t, v[30:0], 0);
                    end
                end
            end
            CMD_SHUT: begin
                for (int i = 0; i < mdl_cores; i++)
                    while (mdl_len[i] > 0) push_result(ST_DELETED, i, take_front(i), 0);
                if (pending_results.size() == n0) push_result(ST_NONE, 0, 0, 0);
            end
            CMD_SIZE: begin
                if (!ok) push_result(ST_FAIL, 0, 0, 0);
                else push_result(ST_SIZE, cid, 0, mdl_len[cid]);
            end
            default: push_result(ST_FAIL, 0, 0, 0);
        endcase
        pending_results[$].last = 1'b1;
        last_st = pending_results[$].status;
    endfunction

    task automatic write_core_count(logic [3:0] n);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {28'd0, n};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mdl_cores = n > NUM_CORES ? NUM_CORES : n;
    endtask

    task automatic send_command(logic [2:0] cmd, logic [3:0] cid, logic [30:0] tid);
        s_axis_tdata <= {2'b0, tid, cid, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_command(cmd, cid, tid);
        @(negedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_command;
        logic [2:0]  cmd;
        logic [30:0] tid;
        int r;
        r = $urandom_range(0, 99);
        cmd = r < 45 ? CMD_SPAWN : r < 70 ? CMD_RUN : r < 80 ? CMD_SLEEP :
              r < 84 ? CMD_SHUT : r < 95 ? CMD_SIZE : 3'($urandom_range(5, 7));
        tid = $urandom_range(0, 15) == 0 ? 31'd0 : 31'($urandom) | 31'd1;
        send_command(cmd, 4'($urandom_range(0, mdl_cores + 2 > 15 ? 15 : mdl_cores + 2)), tid);
    endtask

    // output side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else m_axis_tready <= ((cycles / 37) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge i_clk) begin
        t_result got, exp;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[36:6],
                   m_axis_tdata[40:37], m_axis_tlast};
            if (pending_results.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (got.status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, got.status); errors++;
                end
                if (got.core_index !== exp.core_index) begin
                    $error("core_index exp %0d got %0d", exp.core_index, got.core_index);
                    errors++;
                end
                if (got.task_value !== exp.task_value) begin
                    $error("task_value exp %0h got %0h", exp.task_value, got.task_value);
                    errors++;
                end
                if (got.task_count !== exp.task_count) begin
                    $error("task_count exp %0d got %0d", exp.task_count, got.task_count);
                    errors++;
                end
                if (got.last !== exp.last) begin
                    $error("last exp %0d got %0d", exp.last, got.last); errors++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void add_row(logic [2:0] c, logic [3:0] id, logic [30:0] t,
                                    logic chk = 0, logic [2:0] st = 0);
        t_row r;
        r.cmd = c; r.core_id = id; r.task_id = t; r.chk = chk; r.st = st;
        rows.push_back(r);
    endfunction

    initial begin
        int cfgs[5];
        for (int i = 0; i < NUM_CORES; i++) begin
            mdl_head[i] = 0; mdl_len[i] = 0;
        end
        mdl_cores = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // cores off: everything fails except shutdown
        add_row(CMD_SPAWN, 0, 31'h7fffffff, 1, ST_FAIL);
        add_row(CMD_SIZE, 0, 0, 1, ST_FAIL);
        add_row(CMD_SHUT, 0, 0, 1, ST_NONE);
        for (int i = 0; i < rows.size(); i++) begin
            send_command(rows[i].cmd, rows[i].core_id, rows[i].task_id);
            if (rows[i].chk && last_st !== rows[i].st) begin
                $error("status exp %0d got %0d", rows[i].st, last_st);
                errors++;
            end
        end
        drain();
        write_core_count(4'd15);
        rows.delete();
        add_row(CMD_SPAWN, 0, 0, 1, ST_FAIL);
        add_row(CMD_SPAWN, 15, 31'h7fffffff, 1, ST_ASSIGNED);
        add_row(CMD_SPAWN, 0, 31'h1, 1, ST_ASSIGNED);
        add_row(CMD_SPAWN, 0, 31'h2aaaaaaa);
        add_row(CMD_SPAWN, 0, 31'h55555555);
        add_row(CMD_RUN, 0, 0, 1, ST_RUNNING);
        add_row(CMD_RUN, 0, 0);
        add_row(CMD_RUN, 7, 0);
        add_row(CMD_RUN, 8, 0, 1, ST_FAIL);
        add_row(CMD_SLEEP, 2, 0);
        add_row(CMD_SLEEP, 6, 0, 1, ST_NONE);
        add_row(CMD_SIZE, 15, 0, 1, ST_FAIL);
        add_row(CMD_SIZE, 1, 0, 1, ST_SIZE);
        add_row(3'd5, 0, 0, 1, ST_FAIL);
        add_row(3'd7, 0, 0, 1, ST_FAIL);
        add_row(CMD_SHUT, 0, 0, 1, ST_DELETED);
        for (int i = 0; i < rows.size(); i++) begin
            send_command(rows[i].cmd, rows[i].core_id, rows[i].task_id);
            if (rows[i].chk && last_st !== rows[i].st) begin
                $error("status exp %0d got %0d", rows[i].st, last_st);
                errors++;
            end
        end
        drain();
        // single core: steal skipped, sleep fails; fill to full
        write_core_count(4'd1);
        for (int i = 0; i < 10; i++) send_command(CMD_SPAWN, 0, 31'(i + 100));
        send_command(CMD_SLEEP, 0, 0);
        send_command(CMD_RUN, 0, 0);
        drain();
        // two cores: sleep hits a full target
        write_core_count(4'd2);
        for (int i = 0; i < 9; i++) send_command(CMD_SPAWN, 0, 31'(i + 200));
        send_command(CMD_SLEEP, 0, 0);
        cfgs = '{8, 3, 2, 5, 1};
        foreach (cfgs[k]) begin
            drain();
            write_core_count(4'(cfgs[k]));
            if (k == 1) hold_off = 400;
            for (int i = 0; i < 45; i++) random_command();
        end
        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
